// ----- rtl/djef_pkg.sv -----
`timescale 1ns / 1ps

package djef_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int RING_LEN    = 2 * MAX_WIDTH + 3;
    localparam int SLOT_W      = $clog2(RING_LEN);
    localparam int DIM_W       = 11;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
    localparam int COORD_W     = 16;
    localparam int COS_W       = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int NB_COUNT    = 8;
    localparam int NB_IDX_W    = $clog2(NB_COUNT);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_LIMIT    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_MIN    = DIM_W'(3);
    localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic   valid;
        t_point pt;
    } t_entry;

    // One accepted item, classified by the front end.
    typedef struct packed {
        t_point              pt;
        logic                flush;
        logic [SLOT_W-1:0]   slot;
        logic [DIM_W-1:0]    width;
        logic                has_center;
        logic                border;
        logic                frame_end;
    } t_task;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CREAD,
        BK_CWAIT,
        BK_NB,
        BK_DRAIN,
        BK_EMIT
    } t_bk_state;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        return (v < DIM_MIN) ? DIM_MIN : ((v > hi) ? hi : v);
    endfunction

    // Ring slot that lies 'back' entries behind 'slot'.
    function automatic logic [SLOT_W-1:0] ring_sub(input logic [SLOT_W-1:0] slot,
                                                   input logic [SLOT_W-1:0] back);
        logic [SLOT_W:0] sum;
        if (slot >= back) begin
            sum = {1'b0, slot} - {1'b0, back};
        end else begin
            sum = {1'b0, slot} + (SLOT_W+1)'(RING_LEN) - {1'b0, back};
        end
        return sum[SLOT_W-1:0];
    endfunction

    // Distance back from the newest entry for each of the eight neighbors.
    function automatic logic [SLOT_W-1:0] nb_back(input logic [NB_IDX_W-1:0] idx,
                                                  input logic [DIM_W-1:0] width);
        logic [SLOT_W-1:0] w;
        logic [SLOT_W-1:0] r;
        w = SLOT_W'(width);
        case (idx)
            3'd0:    r = (w << 1) + SLOT_W'(2);
            3'd1:    r = (w << 1) + SLOT_W'(1);
            3'd2:    r = (w << 1);
            3'd3:    r = w + SLOT_W'(2);
            3'd4:    r = w;
            3'd5:    r = SLOT_W'(2);
            3'd6:    r = SLOT_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/depth_jump_edge_filter.sv -----
`timescale 1ns / 1ps

// Jump-edge filter for an organized depth point cloud streamed in raster
// order, one point (x, y, z in mm) per input transfer, or a flush item.
// Each transfer decides the point one row plus one point behind it: points
// on the frame border are kept, empty points vanish, and an interior point
// is dropped when any of its eight neighbors lies nearly on its line of
// sight, (v.d)^2 * 2^30 > cos_limit^2 * |v|^2 * |d|^2. After the H*W points
// of a frame send W+1 flush items to drain out the last row. The front end
// classifies each item and hands it through a four-entry queue to the back
// end, which owns the line store (one write and one registered read port)
// and a six-stage test pipeline fed one neighbor per cycle. An item with no
// point due is only stored; a border point also takes a center read and
// the emit, an interior point eight store reads and the pipeline drain; an
// output stall holds the emit. The store needs no clearing after reset.
// Configuration: index 0 frame_width, 1 frame_height (both clamped to
// 3..1024), 2 cos_limit (Q0.15); write only while the block is idle.

module depth_jump_edge_filter import djef_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic                      i_flush,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COORD_W-1:0] o_out_x,
    output logic signed [COORD_W-1:0] o_out_y,
    output logic signed [COORD_W-1:0] o_out_z,
    output logic                      o_frame_end
);

    logic [DIM_W-1:0] r_frame_width, r_frame_height;
    logic [COS_W-1:0] r_cos_limit;

    t_task f_task, q_task;
    logic  f_valid, f_ready, q_valid, q_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(176);
            r_frame_height <= DIM_W'(144);
            r_cos_limit    <= COS_W'(32270);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_COS_LIMIT:    r_cos_limit    <= i_cfg_data[COS_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position and classification
    djef_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_flush        (i_flush),
        .o_task_valid   (f_valid),
        .i_task_ready   (f_ready),
        .o_task         (f_task)
    );

    // decouples item intake from the neighbor tests
    djef_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_task),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_task)
    );

    // line store, neighbor tests and output register
    djef_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cos_limit  (r_cos_limit),
        .i_task_valid (q_valid),
        .o_task_ready (q_ready),
        .i_task       (q_task),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_frame_end  (o_frame_end)
    );

endmodule

// ----- rtl/djef_front.sv -----
`timescale 1ns / 1ps

module djef_front import djef_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [DIM_W-1:0]          i_frame_width,
    input  logic [DIM_W-1:0]          i_frame_height,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic                      i_flush,
    output logic                      o_task_valid,
    input  logic                      i_task_ready,
    output t_task                     o_task
);

    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic [DIM_W-1:0] w, h, col, row, crow, ccol, col_inc;
    logic             xfer;

    always_comb begin
        w    = clamp_dim(i_frame_width, WIDTH_MAX);
        h    = clamp_dim(i_frame_height, HEIGHT_MAX);
        col  = DIM_W'(r_col);
        row  = DIM_W'(r_row);
        xfer = i_valid && i_task_ready;

        // center point sits one row plus one point behind this item
        if (col != '0) begin
            crow = row - DIM_W'(1);
            ccol = col - DIM_W'(1);
        end else begin
            crow = row - DIM_W'(2);
            ccol = w - DIM_W'(1);
        end

        o_task.pt.x       = i_pos_x;
        o_task.pt.y       = i_pos_y;
        o_task.pt.z       = i_pos_z;
        o_task.flush      = i_flush;
        o_task.slot       = r_slot;
        o_task.width      = w;
        o_task.has_center = (row != '0) && !(row == DIM_W'(1) && col == '0);
        o_task.border     = (crow == '0) || (ccol == '0) || (ccol >= w - DIM_W'(1))
                            || (crow >= h - DIM_W'(1));
        o_task.frame_end  = (crow == h - DIM_W'(1)) && (ccol == w - DIM_W'(1));
        o_task_valid      = i_valid;
        o_ready           = i_task_ready;

        col_inc = col + DIM_W'(1);
        n_col   = r_col;
        n_row   = r_row;
        n_slot  = r_slot;
        if (xfer) begin
            n_slot = (r_slot == SLOT_W'(RING_LEN - 1)) ? '0 : r_slot + SLOT_W'(1);
            if (row >= h + DIM_W'(1)) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= w) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

endmodule

// ----- rtl/djef_queue.sv -----
`timescale 1ns / 1ps

module djef_queue import djef_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_task i_push_data,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_task o_pop_data
);

    t_task             r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              push, pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_buf[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// ----- rtl/djef_back.sv -----
`timescale 1ns / 1ps

module djef_back import djef_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [COS_W-1:0]          i_cos_limit,
    input  logic                      i_task_valid,
    output logic                      o_task_ready,
    input  t_task                     i_task,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COORD_W-1:0] o_out_x,
    output logic signed [COORD_W-1:0] o_out_y,
    output logic signed [COORD_W-1:0] o_out_z,
    output logic                      o_frame_end
);

    // line store, one entry per slot
    t_entry r_mem [RING_LEN];
    t_entry r_rd;

    t_bk_state           r_state, n_state;
    t_task               r_task;
    t_point              r_c;
    logic [NB_IDX_W-1:0] r_nb_idx;
    logic                r_drop;
    logic [2*COS_W-1:0]  r_cc;
    logic [31:0]         r_csq_x, r_csq_y, r_csq_z;
    logic [31:0]         r_vv;

    // neighbor test pipeline
    logic                r_t1, r_t2, r_t3, r_t4, r_t5, r_t6;
    logic signed [16:0]  r_d_x, r_d_y, r_d_z;
    logic signed [32:0]  r_pdot_x, r_pdot_y, r_pdot_z;
    logic [31:0]         r_pdd_x, r_pdd_y, r_pdd_z;
    logic [32:0]         r_dot_abs;
    logic [33:0]         r_dd;
    logic [65:0]         r_dot2, r_vvdd;
    logic [95:0]         r_lhs;
    logic [61:0]         r_rlo;
    logic [63:0]         r_rhi;

    logic                r_out_valid;
    t_point              r_out_pt;
    logic                r_out_fe;

    logic [SLOT_W-1:0]   rd_addr;
    logic                pop, load, busy;
    logic signed [33:0]  sq_x, sq_y, sq_z, csq_x, csq_y, csq_z;
    logic signed [34:0]  dot_sum;
    logic [95:0]         rhs;

    assign pop  = (r_state == BK_IDLE) && i_task_valid;
    assign busy = r_t1 || r_t2 || r_t3 || r_t4 || r_t5 || r_t6;
    assign load = (r_state == BK_EMIT) && !r_drop && (!r_out_valid || i_ready);
    assign o_task_ready = (r_state == BK_IDLE);

    always_comb begin
        if (r_state == BK_CREAD) begin
            rd_addr = ring_sub(r_task.slot, SLOT_W'(r_task.width) + SLOT_W'(1));
        end else begin
            rd_addr = ring_sub(r_task.slot, nb_back(r_nb_idx, r_task.width));
        end
        sq_x    = r_d_x * r_d_x;
        sq_y    = r_d_y * r_d_y;
        sq_z    = r_d_z * r_d_z;
        csq_x   = r_c.x * r_c.x;
        csq_y   = r_c.y * r_c.y;
        csq_z   = r_c.z * r_c.z;
        dot_sum = r_pdot_x + r_pdot_y + r_pdot_z;
        rhs     = 96'(r_rlo) + {r_rhi, 32'd0};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_task_valid && i_task.has_center) begin
                    n_state = BK_CREAD;
                end
            end
            BK_CREAD: n_state = BK_CWAIT;
            BK_CWAIT: begin
                if (!r_rd.valid) begin
                    n_state = BK_IDLE;
                end else if (r_task.border) begin
                    n_state = BK_EMIT;
                end else begin
                    n_state = BK_NB;
                end
            end
            BK_NB: begin
                if (r_nb_idx == NB_IDX_W'(NB_COUNT - 1)) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (!busy) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (r_drop || !r_out_valid || i_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // store write on pop, one registered read each cycle
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_mem[i_task.slot] <= {!i_task.flush, i_task.pt};
        end
        r_rd <= r_mem[rd_addr];
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_task <= i_task;
        end
        if (r_state == BK_CWAIT) begin
            r_c <= r_rd.pt;
        end
        r_cc    <= i_cos_limit * i_cos_limit;
        r_csq_x <= csq_x[31:0];
        r_csq_y <= csq_y[31:0];
        r_csq_z <= csq_z[31:0];
        r_vv    <= r_csq_x + r_csq_y + r_csq_z;

        r_d_x     <= 17'(r_c.x) - 17'(r_rd.pt.x);
        r_d_y     <= 17'(r_c.y) - 17'(r_rd.pt.y);
        r_d_z     <= 17'(r_c.z) - 17'(r_rd.pt.z);
        r_pdot_x  <= r_c.x * r_d_x;
        r_pdot_y  <= r_c.y * r_d_y;
        r_pdot_z  <= r_c.z * r_d_z;
        r_pdd_x   <= sq_x[31:0];
        r_pdd_y   <= sq_y[31:0];
        r_pdd_z   <= sq_z[31:0];
        r_dot_abs <= dot_sum[34] ? 33'(-dot_sum) : 33'(dot_sum);
        r_dd      <= 34'(r_pdd_x) + 34'(r_pdd_y) + 34'(r_pdd_z);
        r_dot2    <= 66'(r_dot_abs) * 66'(r_dot_abs);
        r_vvdd    <= 66'(r_vv) * 66'(r_dd);
        r_lhs     <= {r_dot2, 30'd0};
        r_rlo     <= 62'(r_vvdd[31:0]) * 62'(r_cc);
        r_rhi     <= 64'(r_vvdd[65:32]) * 64'(r_cc);

        if (load) begin
            r_out_pt <= r_c;
            r_out_fe <= r_task.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_nb_idx    <= '0;
            r_drop      <= 1'b0;
            r_t1        <= 1'b0;
            r_t2        <= 1'b0;
            r_t3        <= 1'b0;
            r_t4        <= 1'b0;
            r_t5        <= 1'b0;
            r_t6        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_NB) begin
                r_nb_idx <= r_nb_idx + NB_IDX_W'(1);
            end else begin
                r_nb_idx <= '0;
            end
            r_t1 <= (r_state == BK_NB);
            r_t2 <= r_t1 && r_rd.valid;   // empty neighbor: no test
            r_t3 <= r_t2;
            r_t4 <= r_t3;
            r_t5 <= r_t4 && (r_dd != '0) && (r_vv != '0);
            r_t6 <= r_t5;
            if (pop) begin
                r_drop <= 1'b0;
            end else if (r_t6 && (r_lhs > rhs)) begin
                r_drop <= 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_x     = r_out_pt.x;
    assign o_out_y     = r_out_pt.y;
    assign o_out_z     = r_out_pt.z;
    assign o_frame_end = r_out_fe;

    a_emit_after_tests: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_EMIT) |-> !busy)
        else $error("emit while neighbor tests in flight");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == BK_EMIT))
        else $error("result raised outside emit");

    a_empty_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CWAIT && !r_rd.valid) |=> (r_state == BK_IDLE))
        else $error("empty center not discarded");

    a_no_test_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE) |-> !busy)
        else $error("neighbor test alive while idle");

endmodule
